// File: src/cdq_pkg.sv
// Package with shared types and constants for the circular deque.
`timescale 1ns / 1ps
`default_nettype none
package cdq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic empty;
  } sts_t;

endpackage
`default_nettype wire

// File: src/cdq_ctrl.sv
// Controller state machine for the circular deque handshakes and sequencing.
`timescale 1ns / 1ps
`default_nettype none
module cdq_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cdq_pkg::ACT_W-1:0]        in_action,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  input  wire cdq_pkg::sts_t                    sts,
  output cdq_pkg::cmd_t                         cmd
);

  cdq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            is_pop;
  logic            pop_ok;

  assign is_pop = (in_action == cdq_pkg::ACT_POP_FRONT) ||
                  (in_action == cdq_pkg::ACT_POP_BACK);
  assign pop_ok = is_pop && !sts.empty;
  assign accept = (state_r == cdq_pkg::S_IDLE) && in_valid &&
                  (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        if (accept && pop_ok) begin
          state_nxt = cdq_pkg::S_READ;
        end
      end
      cdq_pkg::S_READ: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.exec      = 1'b0;
    cmd.load_rd   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        in_stall = !accept;
        cmd.exec = accept;
        if (accept && !pop_ok) begin
          out_valid_nxt = 1'b1;
        end
      end
      cdq_pkg::S_READ: begin
        cmd.load_rd   = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/cdq_dp.sv
// Datapath of the circular deque: ring memory, head and count, result register.
`timescale 1ns / 1ps
`default_nettype none
module cdq_dp #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cdq_pkg::cmd_t                    cmd,
  output cdq_pkg::sts_t                         sts,
  input  wire logic [cdq_pkg::ACT_W-1:0]        in_action,
  input  wire logic [cdq_pkg::WORD_W-1:0]       in_push_word,
  output logic [cdq_pkg::WORD_W-1:0]            out_pop_word,
  output logic [cdq_pkg::STAT_W-1:0]            out_status,
  output logic [cdq_pkg::OCC_W-1:0]             out_occupancy
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int EXT_W = (CNT_W > cdq_pkg::OCC_W) ? CNT_W : cdq_pkg::OCC_W;

  logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [cdq_pkg::WORD_W-1:0] rd_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_dec, head_inc;
  logic [SUM_W-1:0] tail_sum, last_sum, tail_wrap, last_wrap;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;
  logic             full, empty;
  logic             pop_ok;
  cdq_pkg::act_t    act;
  cdq_pkg::status_t err_code;
  logic [EXT_W-1:0] occ_nxt_ext, occ_cur_ext;

  logic [cdq_pkg::WORD_W-1:0] pop_word_r;
  logic [cdq_pkg::STAT_W-1:0] status_r;
  logic [cdq_pkg::OCC_W-1:0]  occ_r;

  assign act   = cdq_pkg::act_t'(in_action);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign sts.empty = empty;

  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign last_sum  = tail_sum - 1'b1;
  assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
  assign last_wrap = (last_sum >= SUM_W'(DEPTH)) ? last_sum - SUM_W'(DEPTH) : last_sum;

  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = head_dec;
    rd_addr  = head_r;
    pop_ok   = 1'b0;
    err_code = cdq_pkg::ST_OK;
    if (cmd.exec) begin
      unique case (act)
        cdq_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            err_code = cdq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        cdq_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            err_code = cdq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_wrap[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
        cdq_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            err_code = cdq_pkg::ST_EMPTY;
          end else begin
            pop_ok    = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        cdq_pkg::ACT_POP_BACK: begin
          if (empty) begin
            err_code = cdq_pkg::ST_EMPTY;
          end else begin
            pop_ok    = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = last_wrap[IDX_W-1:0];
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          err_code = cdq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_push_word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign occ_nxt_ext = EXT_W'(count_nxt);
  assign occ_cur_ext = EXT_W'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.exec && !pop_ok) begin
      pop_word_r <= '0;
      status_r   <= err_code;
      occ_r      <= occ_nxt_ext[cdq_pkg::OCC_W-1:0];
    end else if (cmd.load_rd) begin
      pop_word_r <= rd_data_r;
      status_r   <= cdq_pkg::ST_OK;
      occ_r      <= occ_cur_ext[cdq_pkg::OCC_W-1:0];
    end
  end

  assign out_pop_word  = pop_word_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

endmodule
`default_nettype wire

// File: src/circular_deque.sv
// Top level of the circular deque: controller and datapath.
//
//   Channel | Direction | Handshake         | Fields
//   in      | input     | in_valid/in_stall | in_action, in_push_word
//   out     | output    | out_valid/out_stall | out_pop_word, out_status, out_occupancy
//
// A push or a rejected operation loads the result register directly; a successful pop
// first reads the ring memory, which has a registered read port, then loads it.
// An item is taken only while the result register is empty or being drained.
// Reset clears the head and count synchronously; the memory is not cleared.
// A stalled result holds in the output register until taken.
`timescale 1ns / 1ps
`default_nettype none
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cdq_pkg::ACT_W-1:0]        in_action,
  input  wire logic [cdq_pkg::WORD_W-1:0]       in_push_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cdq_pkg::WORD_W-1:0]            out_pop_word,
  output logic [cdq_pkg::STAT_W-1:0]            out_status,
  output logic [cdq_pkg::OCC_W-1:0]             out_occupancy
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_push_word  (in_push_word),
    .out_pop_word  (out_pop_word),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule
`default_nettype wire

// File: dv/tb_circular_deque.sv
// Self-checking testbench for the circular deque: directed and random items.
`timescale 1ns / 1ps
module tb_circular_deque;

  localparam int RUN_ITEMS = 1150;

  typedef struct packed {
    logic [cdq_pkg::WORD_W-1:0] word;
    cdq_pkg::status_t           st;
    logic [cdq_pkg::OCC_W-1:0]  occ;
  } deque_result_t;

  // Mirror of the deque contents that predicts every result.
  class deque_mirror;
    logic [cdq_pkg::WORD_W-1:0] ring [cdq_pkg::DEPTH_DEF];
    int unsigned       head;
    int unsigned       count;
    deque_result_t     want_q[$];
    int unsigned       bad;

    function new();
      head  = 0;
      count = 0;
      bad   = 0;
    endfunction

    function void apply_op(cdq_pkg::act_t op, logic [cdq_pkg::WORD_W-1:0] word);
      deque_result_t r;
      int unsigned   pos;
      r.word = '0;
      r.st   = cdq_pkg::ST_OK;
      case (op) inside
        cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_BACK: begin
          if (count >= cdq_pkg::DEPTH_DEF) begin
            r.st = cdq_pkg::ST_FULL;
          end else begin
            if (op == cdq_pkg::ACT_PUSH_FRONT) begin
              head = (head + cdq_pkg::DEPTH_DEF - 1) % cdq_pkg::DEPTH_DEF;
              pos  = head;
            end else begin
              pos = (head + count) % cdq_pkg::DEPTH_DEF;
            end
            ring[pos] = word;
            count++;
          end
        end
        cdq_pkg::ACT_POP_FRONT: begin
          if (count == 0) begin
            r.st = cdq_pkg::ST_EMPTY;
          end else begin
            r.word = ring[head];
            head   = (head + 1) % cdq_pkg::DEPTH_DEF;
            count--;
          end
        end
        default: begin
          if (count == 0) begin
            r.st = cdq_pkg::ST_EMPTY;
          end else begin
            pos    = (head + count - 1) % cdq_pkg::DEPTH_DEF;
            r.word = ring[pos];
            count--;
          end
        end
      endcase
      r.occ = count[cdq_pkg::OCC_W-1:0];
      want_q.push_back(r);
    endfunction

    function void match_result(logic [cdq_pkg::WORD_W-1:0] word,
                               logic [cdq_pkg::STAT_W-1:0] st,
                               logic [cdq_pkg::OCC_W-1:0] occ);
      deque_result_t r;
      if (want_q.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected result pop_word %h status %0d occupancy %0d",
                   $realtime, word, st, occ);
        return;
      end
      r = want_q.pop_front();
      if (word !== r.word || st !== r.st || occ !== r.occ) begin
        bad++;
        if (bad <= 10)
          $display("%0t: mismatch pop_word exp %h got %h, status exp %0d got %0d, %s %0d got %0d",
                   $realtime, r.word, word, r.st, st, "occupancy exp", r.occ, occ);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [cdq_pkg::ACT_W-1:0]    in_action;
  logic [cdq_pkg::WORD_W-1:0]   in_push_word;
  logic                         out_valid;
  logic                         out_stall;
  logic [cdq_pkg::WORD_W-1:0]   out_pop_word;
  logic [cdq_pkg::STAT_W-1:0]   out_status;
  logic [cdq_pkg::OCC_W-1:0]    out_occupancy;

  deque_mirror mirror;

  circular_deque i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_push_word  (in_push_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_word  (out_pop_word),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Results are checked before the item accepted at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        mirror.match_result(out_pop_word, out_status, out_occupancy);
      if (in_valid && !in_stall)
        mirror.apply_op(cdq_pkg::act_t'(in_action), in_push_word);
    end
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_op(cdq_pkg::act_t op, logic [cdq_pkg::WORD_W-1:0] word, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= op;
    in_push_word <= word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (mirror.want_q.size() != 0);
  endtask

  initial begin
    int unsigned out_n;
    int unsigned stretch;
    bit          quiet;
    out_stall = 1'b0;
    stretch   = 0;
    quiet     = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 60);
        quiet   = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      out_n = draw_gap(quiet);
      @(negedge clk);
      if (out_n > 0) begin
        out_stall <= 1'b1;
        repeat (out_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int            sent;
    int            phase;
    int            phase_len;
    int unsigned   push_pct;
    bit            quiet;
    cdq_pkg::act_t op;
    mirror       = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = cdq_pkg::ACT_PUSH_FRONT;
    in_push_word = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    drive_op(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000, draw_gap(0));
    drive_op(cdq_pkg::ACT_POP_BACK, 32'hFFFF_FFFF, draw_gap(0));
    drive_op(cdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, draw_gap(0));
    drive_op(cdq_pkg::ACT_PUSH_BACK, 32'h0000_0000, draw_gap(0));
    drive_op(cdq_pkg::ACT_PUSH_FRONT, 32'hA5A5_A5A5, 0);
    drive_op(cdq_pkg::ACT_PUSH_BACK, 32'h5A5A_5A5A, 0);
    drive_op(cdq_pkg::ACT_POP_BACK, 32'h0000_0000, 0);
    drive_op(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000, draw_gap(0));
    drive_op(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000, 0);
    drive_op(cdq_pkg::ACT_POP_BACK, 32'h0000_0000, 0);
    drive_op(cdq_pkg::ACT_POP_BACK, 32'h0000_0000, draw_gap(0));
    drive_op(cdq_pkg::ACT_PUSH_BACK, 32'h0000_0001, 0);
    drive_op(cdq_pkg::ACT_PUSH_BACK, 32'h8000_0000, 0);
    drive_op(cdq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFE, draw_gap(0));
    drive_op(cdq_pkg::ACT_POP_BACK, 32'h0000_0000, 0);
    drive_op(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000, 0);
    drive_op(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000, 0);
    wait_drained();

    // The first phase fills the deque past full; later ones pick at random
    // between filling, draining and balanced traffic.
    sent  = 0;
    phase = 0;
    while (sent < RUN_ITEMS) begin
      if (phase == 0) begin
        push_pct = 100;
      end else begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      phase_len = (phase == 0) ? 90 : $urandom_range(60, 130);
      if (phase_len > RUN_ITEMS - sent)
        phase_len = RUN_ITEMS - sent;
      quiet     = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? cdq_pkg::ACT_PUSH_BACK : cdq_pkg::ACT_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? cdq_pkg::ACT_POP_BACK : cdq_pkg::ACT_POP_FRONT;
        drive_op(op, $urandom, draw_gap(quiet));
        sent++;
      end
      if ($urandom_range(0, 3) == 0)
        wait_drained();
      phase++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mirror.bad == 0 && mirror.want_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
